// ----- rtl/cbut_pkg.sv -----
// ----------------------------------------------------------------------------
// cbut_pkg
// Shared types and codes of the block-wise upload tracker: request and
// result transactions, function and status codes, controller states.
// ----------------------------------------------------------------------------
package cbut_pkg;

  // Function codes of a request transaction
  localparam logic [1:0] FUNC_BLOCK1  = 2'd0;
  localparam logic [1:0] FUNC_PLAIN   = 2'd1;
  localparam logic [1:0] FUNC_RELEASE = 2'd2;
  localparam logic [1:0] FUNC_UNUSED  = 2'd3;

  // Status codes of a result transaction
  localparam logic [2:0] STAT_DONE          = 3'd0;
  localparam logic [2:0] STAT_NOT_BLOCKWISE = 3'd1;
  localparam logic [2:0] STAT_WAIT_MORE     = 3'd2;
  localparam logic [2:0] STAT_MISSING       = 3'd3;
  localparam logic [2:0] STAT_OVERFLOW      = 3'd4;

  // Response codes: 2.31 Continue and 4.08 Request Entity Incomplete
  localparam logic [7:0] CODE_CONTINUE   = 8'd95;
  localparam logic [7:0] CODE_INCOMPLETE = 8'd136;

  // Largest legal size exponent; the reserved code folds onto it
  localparam logic [2:0] SZX_MAX      = 3'd6;
  localparam logic [2:0] SZX_RESERVED = 3'd7;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] session_id;
    logic [19:0] block_num;
    logic [2:0]  block_szx;
    logic        more_flag;
    logic [10:0] payload_size;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  response_code;
    logic        option_valid;
    logic [23:0] option_value;
    logic        write_enable;
    logic [15:0] write_offset;
    logic [16:0] assembled_length;
  } rsp_t;

  // Table update requested by the evaluation step
  typedef struct packed {
    logic mem_we;
    logic set_valid;
    logic clr_valid;
  } upd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EVAL
  } state_e;

endpackage

// ----- rtl/coap_block_upload_tracker.sv -----
// ----------------------------------------------------------------------------
// coap_block_upload_tracker
// Block-wise upload tracker: per-session assembled length kept in a slot
// table, one result per request or release transaction.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: a transaction is taken at a clock edge with start_i high
//   and busy_o low; req_i carries the function, session and Block1 fields.
//   Result channel: valid_o is high for exactly one cycle with rsp_o; the
//   receiver cannot stall it, and a new request may be taken in that cycle.
//   Scan: the controller walks the slot table one entry per cycle through
//   the single read port of the slot memory (registered read data), stops
//   at the first matching session, then evaluates and writes back in the
//   evaluation state. The scan runs through the whole table when the
//   session is new or sits in the last slot.
//   The unused function code is dropped at acceptance and gives no result.
//   Reset: slot valid flags clear at once, so the table starts empty with
//   no clearing pass; the slot memory itself is not reset.
// ----------------------------------------------------------------------------
module coap_block_upload_tracker #(
  parameter int SESSIONS = 8,
  parameter int MAX_LEN  = 65536
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  cbut_pkg::req_t req_i,
  output logic           valid_o,
  output cbut_pkg::rsp_t rsp_o
);

  localparam int IW = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int MW = 16 + LW;
  localparam logic [IW-1:0] LastIdx = IW'(SESSIONS - 1);

  cbut_pkg::state_e state_q, state_d;

  // control registers
  logic [SESSIONS-1:0] slot_valid_q;
  logic                issue_on_q;
  logic [IW-1:0]       issue_idx_q;
  logic                rd_pend_q;
  logic                hit_q;
  logic                free_found_q;
  logic                out_valid_q;

  // payload registers
  cbut_pkg::req_t      req_q;
  logic [IW-1:0]       rd_idx_q;
  logic [IW-1:0]       slot_q;
  logic [IW-1:0]       free_idx_q;
  logic [LW-1:0]       cur_q;
  cbut_pkg::rsp_t      rsp_q;

  logic                accept;
  logic                mem_re;
  logic                in_scan;
  logic                in_eval;
  logic [MW-1:0]       rdata;
  logic [15:0]         rd_session;
  logic [LW-1:0]       rd_len;
  logic                match;
  logic                scan_last;
  logic [IW-1:0]       slot_sel;
  logic [LW-1:0]       cur_sel;
  cbut_pkg::rsp_t      eval_rsp;
  cbut_pkg::upd_t      eval_upd;
  logic [LW-1:0]       new_len;

  assign accept     = start_i && !busy_o;
  assign rd_session = rdata[MW-1:LW];
  assign rd_len     = rdata[LW-1:0];
  assign match      = rd_pend_q && slot_valid_q[rd_idx_q] && (rd_session == req_q.session_id);
  assign scan_last  = rd_pend_q && (rd_idx_q == LastIdx);
  assign slot_sel   = hit_q ? slot_q : free_idx_q;
  assign cur_sel    = hit_q ? cur_q : '0;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cbut_pkg::ST_IDLE: begin
        if (accept && req_i.func != cbut_pkg::FUNC_UNUSED) begin
          state_d = cbut_pkg::ST_SCAN;
        end
      end
      cbut_pkg::ST_SCAN: begin
        if (match || scan_last) begin
          state_d = cbut_pkg::ST_EVAL;
        end
      end
      cbut_pkg::ST_EVAL: begin
        state_d = cbut_pkg::ST_IDLE;
      end
      default: begin
        state_d = cbut_pkg::ST_IDLE;
      end
    endcase
  end

  // Controller outputs
  always_comb begin
    busy_o  = 1'b1;
    in_scan = 1'b0;
    in_eval = 1'b0;
    unique case (state_q)
      cbut_pkg::ST_IDLE: busy_o  = 1'b0;
      cbut_pkg::ST_SCAN: in_scan = 1'b1;
      cbut_pkg::ST_EVAL: in_eval = 1'b1;
      default:           busy_o  = 1'b1;
    endcase
  end

  assign mem_re = in_scan && issue_on_q;

  // Slot table storage: session id over assembled length
  cbut_slot_mem #(
    .DEPTH (SESSIONS),
    .WIDTH (MW)
  ) u_slot_mem (
    .clk_i   (clk_i),
    .we_i    (in_eval && eval_upd.mem_we),
    .waddr_i (slot_sel),
    .wdata_i ({req_q.session_id, new_len}),
    .re_i    (mem_re),
    .raddr_i (issue_idx_q),
    .rdata_o (rdata)
  );

  // Evaluate the block against the found or new slot
  cbut_eval #(
    .MAX_LEN (MAX_LEN)
  ) u_eval (
    .req_i       (req_q),
    .hit_i       (hit_q),
    .have_slot_i (hit_q || free_found_q),
    .cur_len_i   (cur_sel),
    .rsp_o       (eval_rsp),
    .upd_o       (eval_upd),
    .new_len_o   (new_len)
  );

  // Control state: scan sequencing, search flags, valid flags, strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cbut_pkg::ST_IDLE;
      slot_valid_q <= '0;
      issue_on_q   <= 1'b0;
      issue_idx_q  <= '0;
      rd_pend_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= in_eval;
      if (accept) begin
        issue_on_q   <= 1'b1;
        issue_idx_q  <= '0;
        rd_pend_q    <= 1'b0;
        hit_q        <= 1'b0;
        free_found_q <= 1'b0;
      end else if (in_scan) begin
        // advance the read address, one entry a cycle
        rd_pend_q <= issue_on_q;
        if (issue_on_q) begin
          if (issue_idx_q == LastIdx) begin
            issue_on_q <= 1'b0;
          end else begin
            issue_idx_q <= issue_idx_q + IW'(1);
          end
        end
        // compare the entry read in the previous cycle
        if (match) begin
          hit_q <= 1'b1;
        end else if (rd_pend_q && !slot_valid_q[rd_idx_q] && !free_found_q) begin
          free_found_q <= 1'b1;
        end
      end else if (in_eval) begin
        if (eval_upd.set_valid) begin
          slot_valid_q[slot_sel] <= 1'b1;
        end
        if (eval_upd.clr_valid) begin
          slot_valid_q[slot_sel] <= 1'b0;
        end
      end
    end
  end

  // Payload: request, scan indexes, slot length, result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    if (mem_re) begin
      rd_idx_q <= issue_idx_q;
    end
    if (in_scan && match) begin
      slot_q <= rd_idx_q;
      cur_q  <= rd_len;
    end
    if (in_scan && rd_pend_q && !slot_valid_q[rd_idx_q] && !free_found_q) begin
      free_idx_q <= rd_idx_q;
    end
    if (in_eval) begin
      rsp_q <= eval_rsp;
    end
  end

  assign valid_o = out_valid_q;
  assign rsp_o   = rsp_q;

endmodule

// ----- rtl/cbut_slot_mem.sv -----
// ----------------------------------------------------------------------------
// cbut_slot_mem
// Slot table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module cbut_slot_mem #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 33,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/cbut_eval.sv -----
// ----------------------------------------------------------------------------
// cbut_eval
// Block evaluation: classifies one transaction against the slot's assembled
// length and forms the result and the table update.
// ----------------------------------------------------------------------------
module cbut_eval #(
  parameter int MAX_LEN = 65536,
  localparam int LW = $clog2(MAX_LEN + 1)
) (
  input  cbut_pkg::req_t  req_i,
  input  logic            hit_i,
  input  logic            have_slot_i,
  input  logic [LW-1:0]   cur_len_i,
  output cbut_pkg::rsp_t  rsp_o,
  output cbut_pkg::upd_t  upd_o,
  output logic [LW-1:0]   new_len_o
);

  localparam int LXW = (LW > 17) ? LW : 17;
  localparam logic [31:0] MaxLenW = 32'(MAX_LEN);

  logic [2:0]     szx_eff;
  logic [3:0]     shamt;
  logic [30:0]    offset;
  logic [31:0]    end_pos;
  logic [31:0]    cur_w;
  logic [LXW-1:0] cur_ext;
  logic           respond;

  // Fold the reserved exponent and form the byte offset of the block
  assign szx_eff = (req_i.block_szx == cbut_pkg::SZX_RESERVED) ? cbut_pkg::SZX_MAX
                                                               : req_i.block_szx;
  assign shamt   = 4'(szx_eff) + 4'd4;
  assign offset  = {11'b0, req_i.block_num} << shamt;
  assign end_pos = 32'(offset) + 32'(req_i.payload_size);
  assign cur_w   = 32'(cur_len_i);
  assign cur_ext = LXW'(cur_len_i);

  // Classify the transaction
  always_comb begin
    respond   = 1'b0;
    rsp_o     = '0;
    upd_o     = '0;
    new_len_o = cur_len_i;
    case (req_i.func) inside
      cbut_pkg::FUNC_RELEASE: begin
        if (hit_i) begin
          if (!req_i.more_flag) begin
            upd_o.clr_valid = 1'b1;
          end else begin
            rsp_o.assembled_length = cur_ext[16:0];
          end
        end
      end
      cbut_pkg::FUNC_BLOCK1, cbut_pkg::FUNC_PLAIN: begin
        if (!have_slot_i) begin
          rsp_o.status = cbut_pkg::STAT_MISSING;
        end else begin
          // a new slot is taken with length zero
          upd_o.set_valid = !hit_i;
          upd_o.mem_we    = !hit_i;
          if (req_i.func == cbut_pkg::FUNC_PLAIN) begin
            rsp_o.status           = cbut_pkg::STAT_NOT_BLOCKWISE;
            rsp_o.assembled_length = cur_ext[16:0];
          end else begin
            respond = 1'b1;
            if (req_i.payload_size != 11'd0) begin
              if (offset != 31'd0 && 32'(offset) > cur_w) begin
                rsp_o.status        = cbut_pkg::STAT_MISSING;
                rsp_o.response_code = cbut_pkg::CODE_INCOMPLETE;
                respond             = 1'b0;
              end else if (offset != 31'd0 && 32'(offset) < cur_w) begin
                // duplicate block: acknowledge only
                respond = 1'b1;
              end else if (end_pos > MaxLenW) begin
                rsp_o.status = cbut_pkg::STAT_OVERFLOW;
                respond      = 1'b0;
              end else begin
                new_len_o          = LW'(end_pos);
                upd_o.mem_we       = 1'b1;
                rsp_o.write_enable = 1'b1;
                rsp_o.write_offset = offset[15:0];
              end
            end
            if (respond && req_i.more_flag) begin
              rsp_o.status        = cbut_pkg::STAT_WAIT_MORE;
              rsp_o.response_code = cbut_pkg::CODE_CONTINUE;
              rsp_o.option_valid  = 1'b1;
              rsp_o.option_value  = {req_i.block_num, req_i.more_flag, szx_eff};
            end
            rsp_o.assembled_length = 17'(new_len_o);
          end
        end
      end
      default: begin
        rsp_o = '0;
      end
    endcase
  end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the block-wise upload tracker. A directed table
// covers restart, append, duplicate, missing block, empty payload, reserved
// size exponent, release with and without Block2 data, unused function and a
// full session table. Random traffic then mixes well-formed uploads per
// session with out-of-order blocks, noise, table flushes and full 64 KiB
// uploads that end in overflow. Each result is checked field by field against
// an in-bench model of the slot table or a directed row's own expectation.
// ----------------------------------------------------------------------------
module tb;
  import cbut_pkg::*;

  localparam int   SESSIONS    = 8;
  localparam int   MAX_LEN     = 65536;
  localparam int   ITEMS       = 1300;
  localparam int   POOL        = 10;
  localparam int   BIG_EVERY   = 450;
  localparam int   STALL_LIMIT = 2000;
  localparam int   TAIL        = SESSIONS + 6;
  localparam logic [7:0] CODE_KEEP = 8'd0;
  localparam rsp_t RSP_ZERO    = '0;

  typedef struct {
    req_t req;
    bit   typed;
    rsp_t want;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  req_t req_i;
  logic valid_o;
  rsp_t rsp_o;

  // Model of the session table
  logic        slot_live [SESSIONS];
  logic [15:0] slot_sid  [SESSIONS];
  logic [16:0] slot_len  [SESSIONS];

  rsp_t      pending_results [$];
  plan_row_t plan [$];
  int        mismatches   = 0;
  int        items_sent   = 0;
  int        stall_cycles = 0;
  int        no_idle_left = 0;
  bit        no_idle      = 1'b0;

  // Upload progress of each session in the traffic pool
  logic [15:0] pool_sid  [POOL];
  int          pool_next [POOL];
  int          pool_last [POOL];
  logic [2:0]  pool_szx  [POOL];
  bit          pool_rel  [POOL];

  coap_block_upload_tracker #(
    .SESSIONS(SESSIONS),
    .MAX_LEN (MAX_LEN)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .busy_o (busy_o),
    .req_i  (req_i),
    .valid_o(valid_o),
    .rsp_o  (rsp_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic req_t mk_req(input logic [1:0] func, input logic [15:0] sid,
                                  input logic [19:0] num, input logic [2:0] szx,
                                  input logic more, input logic [10:0] size);
    req_t r;
    r.func         = func;
    r.session_id   = sid;
    r.block_num    = num;
    r.block_szx    = szx;
    r.more_flag    = more;
    r.payload_size = size;
    return r;
  endfunction

  function automatic rsp_t mk_rsp(input logic [2:0] status, input logic [7:0] code,
                                  input logic opt_v, input logic [23:0] opt,
                                  input logic wr_en, input logic [15:0] wr_off,
                                  input logic [16:0] len);
    rsp_t e;
    e.status           = status;
    e.response_code    = code;
    e.option_valid     = opt_v;
    e.option_value     = opt;
    e.write_enable     = wr_en;
    e.write_offset     = wr_off;
    e.assembled_length = len;
    return e;
  endfunction

  // Advance the table model by one transaction; return 0 when no result follows
  function automatic bit track_upload(input req_t r, output rsp_t res);
    int          i;
    int          slot;
    logic [2:0]  szx;
    logic [63:0] off;
    logic [63:0] cur;
    logic [63:0] fin;
    bit          dup;
    bit          ack;
    res  = '0;
    slot = -1;
    if (r.func == FUNC_UNUSED) return 1'b0;
    szx = (r.block_szx == SZX_RESERVED) ? SZX_MAX : r.block_szx;

    // lowest live slot holding this session
    for (i = 0; i < SESSIONS; i++) begin
      if (slot < 0 && slot_live[i] && slot_sid[i] == r.session_id) slot = i;
    end

    if (r.func == FUNC_RELEASE) begin
      if (slot >= 0) begin
        if (r.more_flag) begin
          res.assembled_length = slot_len[slot];
        end else begin
          slot_live[slot] = 1'b0;
          slot_len[slot]  = '0;
        end
      end
      return 1'b1;
    end

    // claim the lowest free slot for a new session
    for (i = 0; i < SESSIONS; i++) begin
      if (slot < 0 && !slot_live[i]) begin
        slot         = i;
        slot_live[i] = 1'b1;
        slot_sid[i]  = r.session_id;
        slot_len[i]  = '0;
      end
    end

    if (slot < 0) begin
      res.status = STAT_MISSING;
      return 1'b1;
    end
    if (r.func == FUNC_PLAIN) begin
      res.status           = STAT_NOT_BLOCKWISE;
      res.assembled_length = slot_len[slot];
      return 1'b1;
    end

    ack = 1'b1;
    if (r.payload_size != '0) begin
      off = 64'(r.block_num) << (32'(szx) + 4);
      cur = 64'(slot_len[slot]);
      fin = off + 64'(r.payload_size);
      dup = (off != '0) && (off < cur);
      if (off != '0 && off > cur) begin
        res.status        = STAT_MISSING;
        res.response_code = CODE_INCOMPLETE;
        ack               = 1'b0;
      end else if (!dup && fin > 64'(MAX_LEN)) begin
        res.status = STAT_OVERFLOW;
        ack        = 1'b0;
      end else if (!dup) begin
        slot_len[slot]    = fin[16:0];
        res.write_enable  = 1'b1;
        res.write_offset  = off[15:0];
      end
    end
    // echo the option while more blocks are due
    if (ack && r.more_flag) begin
      res.status        = STAT_WAIT_MORE;
      res.response_code = CODE_CONTINUE;
      res.option_valid  = 1'b1;
      res.option_value  = {r.block_num, r.more_flag, szx};
    end
    res.assembled_length = slot_len[slot];
    return 1'b1;
  endfunction

  task automatic add_row(input req_t r, input bit typed, input rsp_t want);
    plan_row_t row;
    row.req   = r;
    row.typed = typed;
    row.want  = want;
    plan.push_back(row);
  endtask

  // Drive one request transaction and queue its expected result
  task automatic send_item(input req_t r, input bit typed, input rsp_t want);
    rsp_t predicted;
    int   gap;
    if (no_idle_left == 0) begin
      no_idle      = ($urandom_range(0, 3) == 0);
      no_idle_left = $urandom_range(10, 60);
    end
    no_idle_left--;
    gap = no_idle ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (track_upload(r, predicted)) pending_results.push_back(typed ? want : predicted);
    if (r.func != FUNC_UNUSED) items_sent++;
  endtask

  // Release every live session and restart the pool
  task automatic flush_table();
    req_t r;
    int   i;
    for (i = 0; i < SESSIONS; i++) begin
      if (slot_live[i]) begin
        r = mk_req(FUNC_RELEASE, slot_sid[i], 20'($urandom), 3'($urandom), 1'b0,
                   11'($urandom_range(0, 1024)));
        send_item(r, 1'b0, RSP_ZERO);
      end
    end
    for (i = 0; i < POOL; i++) begin
      pool_next[i] = 0;
      pool_rel[i]  = 1'b0;
    end
  endtask

  // Fill one session to exactly 64 KiB, then push one block past the end
  task automatic big_upload();
    req_t        r;
    int          n;
    logic [15:0] sid;
    flush_table();
    sid = 16'($urandom);
    for (n = 0; n <= 64; n++) begin
      r = mk_req(FUNC_BLOCK1, sid, 20'(n),
                 ($urandom_range(0, 3) == 0) ? SZX_RESERVED : SZX_MAX,
                 (n < 64) ? 1'b1 : 1'($urandom),
                 (n < 64) ? 11'd1024 : 11'($urandom_range(1, 1024)));
      send_item(r, 1'b0, RSP_ZERO);
    end
    send_item(mk_req(FUNC_RELEASE, sid, 20'd0, 3'd0, 1'b0, 11'd0), 1'b0, RSP_ZERO);
  endtask

  // Compare one result field
  function automatic void check_field(input string field, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // Check each result transaction against the oldest expectation
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && valid_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction waiting: status %0d", rsp_o.status);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(rsp_o.status));
        check_field("response_code", 32'(want.response_code), 32'(rsp_o.response_code));
        check_field("option_valid", 32'(want.option_valid), 32'(rsp_o.option_valid));
        check_field("option_value", 32'(want.option_value), 32'(rsp_o.option_value));
        check_field("write_enable", 32'(want.write_enable), 32'(rsp_o.write_enable));
        check_field("write_offset", 32'(want.write_offset), 32'(rsp_o.write_offset));
        check_field("assembled_length", 32'(want.assembled_length),
                    32'(rsp_o.assembled_length));
      end
    end
  end

  // Watchdog: end the run after too many cycles without a transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || valid_o === 1'b1) begin
      stall_cycles = 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      stall_cycles++;
    end
  end

  initial begin
    req_t r;
    int   i;
    int   k;
    int   n;
    int   pick;
    int   bs;
    int   next_big;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '0;
    for (i = 0; i < SESSIONS; i++) begin
      slot_live[i] = 1'b0;
      slot_sid[i]  = '0;
      slot_len[i]  = '0;
    end

    // first block of a fresh session opens the upload
    add_row(mk_req(FUNC_BLOCK1, 16'h0001, 20'd0, 3'd0, 1'b1, 11'd16), 1'b1,
            mk_rsp(STAT_WAIT_MORE, CODE_CONTINUE, 1'b1, 24'h000008, 1'b1, 16'd0, 17'd16));
    add_row(mk_req(FUNC_BLOCK1, 16'h0001, 20'd1, 3'd0, 1'b1, 11'd16), 1'b0, RSP_ZERO);
    // duplicate block, last one
    add_row(mk_req(FUNC_BLOCK1, 16'h0001, 20'd1, 3'd0, 1'b0, 11'd16), 1'b0, RSP_ZERO);
    // block beyond the assembled length
    add_row(mk_req(FUNC_BLOCK1, 16'h0001, 20'd5, 3'd0, 1'b1, 11'd16), 1'b1,
            mk_rsp(STAT_MISSING, CODE_INCOMPLETE, 1'b0, 24'd0, 1'b0, 16'd0, 17'd32));
    // empty payloads
    add_row(mk_req(FUNC_BLOCK1, 16'h0001, 20'd2, 3'd0, 1'b0, 11'd0), 1'b0, RSP_ZERO);
    add_row(mk_req(FUNC_BLOCK1, 16'h0001, 20'd2, 3'd0, 1'b1, 11'd0), 1'b0, RSP_ZERO);
    // reserved size exponent acts as 1 KiB blocks, echo included
    add_row(mk_req(FUNC_BLOCK1, 16'h0001, 20'd2, SZX_RESERVED, 1'b1, 11'd16), 1'b0, RSP_ZERO);
    add_row(mk_req(FUNC_BLOCK1, 16'h0001, 20'd0, SZX_RESERVED, 1'b1, 11'd1024), 1'b1,
            mk_rsp(STAT_WAIT_MORE, CODE_CONTINUE, 1'b1, 24'h00000E, 1'b1, 16'd0, 17'd1024));
    add_row(mk_req(FUNC_BLOCK1, 16'h0001, 20'd1, SZX_MAX, 1'b0, 11'd1024), 1'b0, RSP_ZERO);
    add_row(mk_req(FUNC_PLAIN, 16'h0001, 20'd0, 3'd0, 1'b0, 11'd0), 1'b0, RSP_ZERO);
    // release holds the slot while Block2 data follows, then frees it
    add_row(mk_req(FUNC_RELEASE, 16'h0001, 20'd0, 3'd0, 1'b1, 11'd0), 1'b0, RSP_ZERO);
    add_row(mk_req(FUNC_RELEASE, 16'h0001, 20'd0, 3'd0, 1'b0, 11'd0), 1'b1, RSP_ZERO);
    add_row(mk_req(FUNC_RELEASE, 16'h7777, 20'd3, 3'd2, 1'b0, 11'd5), 1'b1, RSP_ZERO);
    add_row(mk_req(FUNC_UNUSED, 16'h0001, 20'd0, 3'd0, 1'b1, 11'd16), 1'b0, RSP_ZERO);
    // fill every slot
    add_row(mk_req(FUNC_BLOCK1, 16'hFFFF, 20'd0, 3'd3, 1'b1, 11'd128), 1'b0, RSP_ZERO);
    add_row(mk_req(FUNC_PLAIN, 16'h0000, 20'hFFFFF, 3'd7, 1'b1, 11'd1024), 1'b0, RSP_ZERO);
    add_row(mk_req(FUNC_BLOCK1, 16'h0010, 20'd0, 3'd1, 1'b0, 11'd32), 1'b0, RSP_ZERO);
    add_row(mk_req(FUNC_PLAIN, 16'h0011, 20'd0, 3'd0, 1'b0, 11'd0), 1'b0, RSP_ZERO);
    add_row(mk_req(FUNC_PLAIN, 16'h0012, 20'd0, 3'd0, 1'b0, 11'd0), 1'b0, RSP_ZERO);
    add_row(mk_req(FUNC_BLOCK1, 16'h0013, 20'd0, 3'd2, 1'b0, 11'd64), 1'b0, RSP_ZERO);
    add_row(mk_req(FUNC_PLAIN, 16'h0014, 20'd0, 3'd0, 1'b0, 11'd0), 1'b0, RSP_ZERO);
    add_row(mk_req(FUNC_BLOCK1, 16'h0015, 20'd0, 3'd5, 1'b1, 11'd512), 1'b0, RSP_ZERO);
    // table full
    add_row(mk_req(FUNC_BLOCK1, 16'h5555, 20'd0, 3'd0, 1'b1, 11'd16), 1'b1,
            mk_rsp(STAT_MISSING, CODE_KEEP, 1'b0, 24'd0, 1'b0, 16'd0, 17'd0));
    add_row(mk_req(FUNC_PLAIN, 16'hAAAA, 20'd0, 3'd0, 1'b0, 11'd0), 1'b1,
            mk_rsp(STAT_MISSING, CODE_KEEP, 1'b0, 24'd0, 1'b0, 16'd0, 17'd0));
    // freed slot goes to a new session; top block number is far ahead
    add_row(mk_req(FUNC_RELEASE, 16'h0000, 20'd0, 3'd0, 1'b0, 11'd0), 1'b1, RSP_ZERO);
    add_row(mk_req(FUNC_BLOCK1, 16'hAAAA, 20'hFFFFF, SZX_RESERVED, 1'b1, 11'd1024), 1'b1,
            mk_rsp(STAT_MISSING, CODE_INCOMPLETE, 1'b0, 24'd0, 1'b0, 16'd0, 17'd0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[j]) send_item(plan[j].req, plan[j].typed, plan[j].want);

    for (i = 0; i < POOL; i++) begin
      pool_sid[i]  = 16'($urandom);
      pool_next[i] = 0;
      pool_last[i] = 0;
      pool_szx[i]  = '0;
      pool_rel[i]  = 1'b0;
    end

    next_big = items_sent;
    while (items_sent < ITEMS) begin
      if (items_sent >= next_big) begin
        big_upload();
        next_big += BIG_EVERY;
      end
      k    = $urandom_range(0, POOL - 1);
      pick = $urandom_range(0, 199);
      if (pick < 140) begin
        // next step of a well-formed upload: blocks in order, then release
        if (pool_rel[k]) begin
          r = mk_req(FUNC_RELEASE, pool_sid[k], 20'($urandom), 3'($urandom),
                     ($urandom_range(0, 3) == 0), 11'($urandom_range(0, 1024)));
          if (!r.more_flag) begin
            pool_rel[k]  = 1'b0;
            pool_next[k] = 0;
          end
        end else begin
          if (pool_next[k] == 0) begin
            pool_szx[k]  = 3'($urandom);
            pool_last[k] = $urandom_range(0, 6);
          end
          bs = (pool_szx[k] == SZX_RESERVED) ? 1024 : (16 << pool_szx[k]);
          r = mk_req(FUNC_BLOCK1, pool_sid[k], 20'(pool_next[k]), pool_szx[k],
                     (pool_next[k] != pool_last[k]),
                     (pool_next[k] == pool_last[k]) ? 11'($urandom_range(0, bs)) : 11'(bs));
          if (r.more_flag) pool_next[k]++;
          else pool_rel[k] = 1'b1;
        end
      end else if (pick < 160) begin
        // block near the expected one: duplicate, gap or in order
        n = pool_next[k] + int'($urandom_range(0, 4)) - 2;
        if (n < 0) n = 0;
        r = mk_req(FUNC_BLOCK1, pool_sid[k], 20'(n), pool_szx[k], 1'($urandom),
                   11'($urandom_range(0, 1024)));
      end else if (pick < 196) begin
        // noise over every field
        r = mk_req(2'($urandom),
                   ($urandom_range(0, 1) == 1) ? pool_sid[k] : 16'($urandom),
                   ($urandom_range(0, 1) == 1) ? 20'($urandom) : 20'($urandom_range(0, 8)),
                   3'($urandom), 1'($urandom), 11'($urandom_range(0, 1024)));
      end else begin
        flush_table();
        continue;
      end
      send_item(r, 1'b0, RSP_ZERO);
    end

    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TAIL) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/cbut_pkg.sv
rtl/cbut_slot_mem.sv
rtl/cbut_eval.sv
rtl/coap_block_upload_tracker.sv
tb/sv/tb.sv
